>>> src/hts_pkg.sv
package hts_pkg;

    localparam int TAG_CHARS   = 8;
    localparam int STRIP_SLOTS = 6;
    localparam int NAME_W      = 64;
    localparam int LEN_W       = $clog2(TAG_CHARS + 1);
    localparam int NAME_IDX_W  = (TAG_CHARS > 1) ? $clog2(TAG_CHARS) : 1;
    localparam int COUNT_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] C_BANG   = 8'h21;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_CR     = 8'h0D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIP_TAG_0 = 3'd0,
        CFG_STRIP_TAG_1 = 3'd1,
        CFG_STRIP_TAG_2 = 3'd2,
        CFG_STRIP_TAG_3 = 3'd3,
        CFG_STRIP_TAG_4 = 3'd4,
        CFG_STRIP_TAG_5 = 3'd5,
        CFG_STRIP_COUNT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic              in_tag;
        logic              closing_tag;
        logic              last_was_slash;
        logic              name_complete;
        logic              space_emitted;
        logic              in_quote;
        logic [7:0]        quote_char;
        logic              escape_parity;
        logic              in_declaration;
        logic              in_comment;
        logic              last_was_minus;
        logic              in_strip_block;
        logic [NAME_W-1:0] tag_name;
        logic [LEN_W-1:0]  name_length;
        logic [NAME_W-1:0] active_strip_name;
    } t_parse;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
    } t_q_wr;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] data;
    } t_q_stat;

    function automatic logic is_space(input logic [7:0] b);
        return (b == C_SPACE) || (b >= C_TAB && b <= C_CR);
    endfunction

    function automatic t_parse parse_reset();
        t_parse r;
        r               = '0;
        r.space_emitted = 1'b1;
        return r;
    endfunction

    function automatic t_parse tag_end_check(input t_parse s, input logic [7:0] b);
        t_parse r;
        r = s;
        if (b == C_SLASH) begin
            r.last_was_slash = 1'b1;
        end else begin
            if (b == C_GT) begin
                r.in_quote       = 1'b0;
                r.in_comment     = 1'b0;
                r.in_declaration = 1'b0;
                r.in_tag         = 1'b0;
                if (s.last_was_slash) begin
                    r.in_strip_block = 1'b0;
                end
            end
            r.last_was_slash = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> src/hts_front.sv
module hts_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_byte,
    input  logic                          i_restart,
    input  logic                          i_cfg_valid,
    input  logic [hts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hts_pkg::NAME_W-1:0]    i_cfg_data,
    input  hts_pkg::t_q_stat              i_q_stat,
    output hts_pkg::t_q_wr                o_q_wr
);
    import hts_pkg::*;

    t_parse                    r_st;
    t_parse                    n_st;
    logic [NAME_W-1:0]         r_strip_tag [STRIP_SLOTS];
    logic [COUNT_W-1:0]        r_strip_count;
    logic [COUNT_W-1:0]        used_slots;
    logic [STRIP_SLOTS-1:0]    slot_hit;
    logic                      accept;
    logic                      emit;
    logic [7:0]                emit_byte;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_count <= '0;
            for (int i = 0; i < STRIP_SLOTS; i++) begin
                r_strip_tag[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < STRIP_SLOTS; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i)) begin
                    r_strip_tag[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == CFG_STRIP_COUNT) begin
                r_strip_count <= i_cfg_data[COUNT_W-1:0];
            end
        end
    end

    assign used_slots = (r_strip_count > COUNT_W'(STRIP_SLOTS)) ?
                        COUNT_W'(STRIP_SLOTS) : r_strip_count;

    always_comb begin
        for (int i = 0; i < STRIP_SLOTS; i++) begin
            slot_hit[i] = (COUNT_W'(i) < used_slots) && (r_st.tag_name == r_strip_tag[i]);
        end
    end

    always_comb begin
        n_st      = r_st;
        emit      = 1'b0;
        emit_byte = i_byte;
        if (i_restart) begin
            n_st.in_tag         = 1'b0;
            n_st.closing_tag    = 1'b0;
            n_st.last_was_slash = 1'b0;
            n_st.name_complete  = 1'b0;
            n_st.space_emitted  = 1'b1;
            n_st.in_quote       = 1'b0;
            n_st.in_declaration = 1'b0;
            n_st.in_comment     = 1'b0;
            n_st.last_was_minus = 1'b0;
            n_st.in_strip_block = 1'b0;
        end
        if (!n_st.in_tag) begin
            if (i_byte == C_LT) begin
                n_st.in_tag        = 1'b1;
                n_st.tag_name      = '0;
                n_st.name_length   = '0;
                n_st.name_complete = 1'b0;
                n_st.closing_tag   = 1'b0;
                if (!n_st.space_emitted) begin
                    n_st.space_emitted = 1'b1;
                    emit               = 1'b1;
                    emit_byte          = C_SPACE;
                end
            end else if (!n_st.in_strip_block) begin
                n_st.space_emitted = 1'b0;
                emit               = 1'b1;
            end
        end else if (!n_st.name_complete && !n_st.in_declaration) begin
            if (n_st.name_length == '0 && i_byte == C_BANG) begin
                n_st.in_declaration = 1'b1;
            end else if (n_st.name_length == '0 && i_byte == C_SLASH) begin
                n_st.closing_tag = 1'b1;
            end else if (!is_space(i_byte) && i_byte != C_SLASH && i_byte != C_GT &&
                         n_st.name_length < LEN_W'(TAG_CHARS)) begin
                n_st.tag_name[8*n_st.name_length[NAME_IDX_W-1:0] +: 8] = i_byte;
                n_st.name_length = n_st.name_length + LEN_W'(1);
            end else begin
                n_st.name_complete = 1'b1;
                if (n_st.in_strip_block && n_st.closing_tag) begin
                    if (n_st.tag_name == n_st.active_strip_name) begin
                        n_st.in_strip_block = 1'b0;
                    end
                end else if (!n_st.in_strip_block && !n_st.closing_tag) begin
                    if (|slot_hit) begin
                        n_st.in_strip_block    = 1'b1;
                        n_st.active_strip_name = n_st.tag_name;
                    end
                end
                n_st = tag_end_check(n_st, i_byte);
            end
        end else if (n_st.in_quote) begin
            if (i_byte == n_st.quote_char && !n_st.escape_parity) begin
                n_st.quote_char = '0;
                n_st.in_quote   = 1'b0;
            end
            n_st.escape_parity = (i_byte == C_BSLASH) ? !n_st.escape_parity : 1'b0;
        end else if (i_byte == C_SQUOTE || i_byte == C_DQUOTE) begin
            n_st.in_quote       = 1'b1;
            n_st.quote_char     = i_byte;
            n_st.last_was_minus = 1'b0;
            n_st.last_was_slash = 1'b0;
        end else if (n_st.in_declaration) begin
            if (n_st.last_was_minus) begin
                if (i_byte == C_MINUS) begin
                    n_st.in_comment = !n_st.in_comment;
                end
                n_st.last_was_minus = 1'b0;
            end else if (i_byte == C_MINUS) begin
                n_st.last_was_minus = 1'b1;
            end
            if (!n_st.in_comment) begin
                n_st = tag_end_check(n_st, i_byte);
            end
        end else begin
            n_st = tag_end_check(n_st, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= parse_reset();
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    assign o_q_wr.push = accept && emit;
    assign o_q_wr.data = emit_byte;

    a_no_text_in_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_st.in_tag && !i_restart) |-> !o_q_wr.push)
        else $error("byte emitted while inside a tag");

    a_space_on_tag_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_wr.push && i_byte == C_LT) |-> (o_q_wr.data == C_SPACE))
        else $error("tag open emitted a byte other than space");

endmodule

>>> src/hts_queue.sv
module hts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hts_pkg::t_q_wr   i_wr,
    input  logic             i_pop,
    output hts_pkg::t_q_stat o_stat
);
    import hts_pkg::*;

    logic [7:0]         r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.data  = r_mem[r_rd_ptr];

    assign do_push = i_wr.push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !o_stat.full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= Q_CNT_W'(Q_DEPTH)) &&
        ((r_count == '0) || (r_count == Q_CNT_W'(Q_DEPTH)) || (r_wr_ptr != r_rd_ptr)))
        else $error("queue pointers disagree with count");

endmodule

>>> src/hts_back.sv
module hts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hts_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data
);
    import hts_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;

    assign o_pop   = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_stat.data;
        end
    end

endmodule

>>> src/html_tag_stripper.sv
// HTML tag stripper: takes one byte per cycle on the slave stream and passes
// on the text between tags, each group of tags as a single space, holding back
// text inside configured strip blocks. The parser steps its state once per
// accepted byte, including the six-way strip tag compare, so a new byte is
// taken every cycle while the four-entry output queue has room; the output
// register drains one byte per cycle when the sink is ready; a passed byte
// is queued first. Write strip tags and the slot count only while idle.
module html_tag_stripper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] in_byte
    input  logic                          i_s_axis_tuser,  // [0] restart
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // [7:0] out_byte
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hts_pkg::NAME_W-1:0]    i_cfg_data
);
    import hts_pkg::*;

    t_q_wr   q_wr;
    t_q_stat q_stat;
    logic    q_pop;

    assign o_cfg_ready = 1'b1;

    hts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_restart   (i_s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_q_wr      (q_wr)
    );

    hts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_stat  (q_stat)
    );

    hts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule
